// File: hw/rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies.
`timescale 1ns / 1ps

package mi3_pkg;

  localparam int LIMB_W = 32;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// File: hw/rtl/mi3_umul.sv
// Pipelined unsigned multiplier built from 32x32 limb products, two stages.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_umul
  import mi3_pkg::*;
#(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  pipe_ctl_t         ctl,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  input  logic [SW-1:0]     side_in,
  output logic              valid_out,
  output logic [AW+BW-1:0]  p,
  output logic [SW-1:0]     side_out
);

  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
  localparam int XW = (NA + NB) * LIMB_W;

  logic [NA*LIMB_W-1:0]  ax;
  logic [NB*LIMB_W-1:0]  bx;
  logic [2*LIMB_W-1:0]   pp [NA][NB];
  logic                  v1;
  logic [SW-1:0]         side1;
  logic [XW-1:0]         acc;

  assign ax = (NA*LIMB_W)'(a);
  assign bx = (NB*LIMB_W)'(b);

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (XW'(pp[i][j]) << ((i + j) * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      valid_out <= 1'b0;
    end else if (ctl.en) begin
      v1        <= ctl.valid;
      valid_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ax[i*LIMB_W +: LIMB_W] * bx[j*LIMB_W +: LIMB_W];
        end
      end
      side1    <= side_in;
      p        <= acc[AW+BW-1:0];
      side_out <= side1;
    end
  end

endmodule

// File: hw/rtl/mi3_recip.sv
// Pipelined restoring divider: floor(2^P / d), one quotient bit per stage.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_recip
  import mi3_pkg::*;
#(
  parameter int DW = 96,
  parameter int P  = 100,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  pipe_ctl_t      ctl,
  input  logic [DW-1:0]  d,
  input  logic [SW-1:0]  side_in,
  output logic           valid_out,
  output logic [P:0]     q,
  output logic [SW-1:0]  side_out
);

  logic [DW-1:0] rem   [P];
  logic [DW-1:0] dreg  [P];
  logic [P:0]    qreg  [P+1];
  logic [SW-1:0] sreg  [P+1];
  logic          vreg  [P+1];

  logic [DW-1:0] cur_rem [P+1];
  logic [DW-1:0] cur_d   [P+1];
  logic [P:0]    cur_q   [P+1];
  logic [SW-1:0] cur_s   [P+1];
  logic          cur_v   [P+1];
  logic [DW:0]   t       [P+1];
  logic          ge      [P+1];
  logic [DW-1:0] nrem    [P+1];
  logic [P:0]    nq      [P+1];

  always_comb begin
    cur_rem[0] = '0;
    cur_d[0]   = d;
    cur_q[0]   = '0;
    cur_s[0]   = side_in;
    cur_v[0]   = ctl.valid;
    for (int s = 1; s <= P; s++) begin
      cur_rem[s] = rem[s-1];
      cur_d[s]   = dreg[s-1];
      cur_q[s]   = qreg[s-1];
      cur_s[s]   = sreg[s-1];
      cur_v[s]   = vreg[s-1];
    end
    for (int s = 0; s <= P; s++) begin
      t[s]    = {cur_rem[s], (s == 0)};
      ge[s]   = t[s] >= (DW+1)'(cur_d[s]);
      nrem[s] = ge[s] ? DW'(t[s] - (DW+1)'(cur_d[s])) : t[s][DW-1:0];
      nq[s]   = cur_q[s] | ((P+1)'(ge[s]) << (P - s));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= P; s++) vreg[s] <= 1'b0;
    end else if (ctl.en) begin
      for (int s = 0; s <= P; s++) vreg[s] <= cur_v[s];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int s = 0; s < P; s++) begin
        rem[s]  <= nrem[s];
        dreg[s] <= cur_d[s];
      end
      for (int s = 0; s <= P; s++) begin
        qreg[s] <= nq[s];
        sreg[s] <= cur_s[s];
      end
    end
  end

  assign valid_out = vreg[P];
  assign q         = qreg[P];
  assign side_out  = sreg[P];

endmodule

// File: hw/rtl/matrix_inverse_3x3_core.sv
// 3x3 fixed-point matrix inverse by adjugate and one reciprocal, fully pipelined.
// Depends on mi3_pkg, mi3_umul, mi3_recip.
//
//   channel | signals                           | dir
//   input   | in_valid in_ready a00..a22        | in
//   output  | out_valid out_ready b00..b22      | out
//           | singular saturated                |
//
// One matrix per cycle while the output is not stalled; the divider resolves
// one quotient bit per stage.
// Reset clears only the valid bits along the pipe.
// When the output holds a result that is not taken, the whole pipe holds.
`timescale 1ns / 1ps

module matrix_inverse_3x3_core
  import mi3_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ELEM_WIDTH-1:0] a00,
  input  logic signed [ELEM_WIDTH-1:0] a01,
  input  logic signed [ELEM_WIDTH-1:0] a02,
  input  logic signed [ELEM_WIDTH-1:0] a10,
  input  logic signed [ELEM_WIDTH-1:0] a11,
  input  logic signed [ELEM_WIDTH-1:0] a12,
  input  logic signed [ELEM_WIDTH-1:0] a20,
  input  logic signed [ELEM_WIDTH-1:0] a21,
  input  logic signed [ELEM_WIDTH-1:0] a22,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ELEM_WIDTH-1:0] b00,
  output logic signed [ELEM_WIDTH-1:0] b01,
  output logic signed [ELEM_WIDTH-1:0] b02,
  output logic signed [ELEM_WIDTH-1:0] b10,
  output logic signed [ELEM_WIDTH-1:0] b11,
  output logic signed [ELEM_WIDTH-1:0] b12,
  output logic signed [ELEM_WIDTH-1:0] b20,
  output logic signed [ELEM_WIDTH-1:0] b21,
  output logic signed [ELEM_WIDTH-1:0] b22,
  output logic                         singular,
  output logic                         saturated
);

  localparam int W    = ELEM_WIDTH;
  localparam int AMW  = 2 * W;
  localparam int DW   = 3 * W;
  localparam int P    = 2 * W + 2 * FRAC_BITS + 4;
  localparam int OS   = P - 2 * FRAC_BITS;
  localparam int PW   = AMW + P + 1;
  localparam int RW   = PW + 1 - OS;
  localparam int PKW  = 9 * (AMW + 1);
  localparam int A0W  = 3 * (W + 1);
  localparam int RSW  = PKW + 2;

  localparam int CP [36] = '{4,8,7,5, 2,7,1,8, 1,5,2,4, 5,6,3,8, 0,8,2,6,
                             3,2,0,5, 3,7,6,4, 6,1,0,7, 0,4,3,1};

  localparam logic [W-1:0]  MAXP    = {1'b0, {(W-1){1'b1}}};
  localparam logic          ONE_SAT = (FRAC_BITS >= W - 1);
  localparam logic [W-1:0]  ONE_V   = ONE_SAT ? MAXP : W'(64'(1) << FRAC_BITS);
  localparam logic [RW-1:0] LIM_P   = RW'(MAXP);
  localparam logic [RW-1:0] LIM_N   = RW'(MAXP) + RW'(1);
  localparam logic [PW:0]   HALF    = (PW+1)'(1) << (OS - 1);

  logic      en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: sign-magnitude inputs
  logic [W-1:0] a_in [9];
  logic [W-1:0] mag  [9];
  logic         neg  [9];
  logic         v_a;

  assign a_in[0] = a00;
  assign a_in[1] = a01;
  assign a_in[2] = a02;
  assign a_in[3] = a10;
  assign a_in[4] = a11;
  assign a_in[5] = a12;
  assign a_in[6] = a20;
  assign a_in[7] = a21;
  assign a_in[8] = a22;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        neg[i] <= a_in[i][W-1];
        mag[i] <= a_in[i][W-1] ? W'(-a_in[i]) : a_in[i];
      end
    end
  end

  // cofactor products
  logic [AMW-1:0] prod  [18];
  logic           psign [18];
  logic           v_b;
  pipe_ctl_t      ctl_a;

  assign ctl_a = '{en: en, valid: v_a};

  for (genvar k = 0; k < 18; k++) begin : g_cof
    logic sgn;
    assign sgn = neg[CP[2*k]] ^ neg[CP[2*k+1]];
    if (k == 0) begin : g_first
      mi3_umul #(.AW(W), .BW(W), .SW(1)) u_mul (
        .clk, .rst, .ctl(ctl_a), .a(mag[CP[2*k]]), .b(mag[CP[2*k+1]]),
        .side_in(sgn), .valid_out(v_b), .p(prod[k]), .side_out(psign[k])
      );
    end else begin : g_rest
      mi3_umul #(.AW(W), .BW(W), .SW(1)) u_mul (
        .clk, .rst, .ctl(ctl_a), .a(mag[CP[2*k]]), .b(mag[CP[2*k+1]]),
        .side_in(sgn), .valid_out(), .p(prod[k]), .side_out(psign[k])
      );
    end
  end

  // first row kept for the determinant
  logic [A0W-1:0] a0_a, a0_1, a0_b, a0_c, a0_d;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a0_a[j*W +: W]   = mag[j];
      a0_a[3*W + j]    = neg[j];
    end
  end

  // stage C: signed cofactor differences; stage D: sign-magnitude adjugate
  logic signed [AMW+1:0] adj_c [9];
  logic [PKW-1:0]        pk_d;
  logic                  v_c, v_d;

  always_ff @(posedge clk) begin
    if (en) begin
      a0_1 <= a0_a;
      a0_b <= a0_1;
      a0_c <= a0_b;
      a0_d <= a0_c;
      for (int e = 0; e < 9; e++) begin
        adj_c[e] <= (psign[2*e]   ? -$signed({2'b00, prod[2*e]})   : $signed({2'b00, prod[2*e]}))
                  - (psign[2*e+1] ? -$signed({2'b00, prod[2*e+1]}) : $signed({2'b00, prod[2*e+1]}));
      end
      for (int e = 0; e < 9; e++) begin
        pk_d[e*AMW +: AMW] <= adj_c[e][AMW+1] ? AMW'(-adj_c[e]) : adj_c[e][AMW-1:0];
        pk_d[9*AMW + e]    <= adj_c[e][AMW+1];
      end
    end
  end

  // determinant products
  logic [DW-1:0] dprod [3];
  logic          dsign [3];
  logic          v_e;
  pipe_ctl_t     ctl_d;

  assign ctl_d = '{en: en, valid: v_d};

  for (genvar j = 0; j < 3; j++) begin : g_det
    logic sgn;
    assign sgn = a0_d[3*W + j] ^ pk_d[9*AMW + 3*j];
    if (j == 0) begin : g_first
      mi3_umul #(.AW(W), .BW(AMW), .SW(1)) u_mul (
        .clk, .rst, .ctl(ctl_d), .a(a0_d[j*W +: W]), .b(pk_d[3*j*AMW +: AMW]),
        .side_in(sgn), .valid_out(v_e), .p(dprod[j]), .side_out(dsign[j])
      );
    end else begin : g_rest
      mi3_umul #(.AW(W), .BW(AMW), .SW(1)) u_mul (
        .clk, .rst, .ctl(ctl_d), .a(a0_d[j*W +: W]), .b(pk_d[3*j*AMW +: AMW]),
        .side_in(sgn), .valid_out(), .p(dprod[j]), .side_out(dsign[j])
      );
    end
  end

  // stage F: signed sum; stage G: |det|
  logic [PKW-1:0]      pk_1, pk_e, pk_f, pk_g;
  logic signed [DW+1:0] dsum_f;
  logic [DW-1:0]       dmag_g;
  logic                dneg_g, dzero_g, v_f, v_g;
  logic signed [DW+1:0] dterm [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dterm[j] = dsign[j] ? -$signed({2'b00, dprod[j]}) : $signed({2'b00, dprod[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pk_1    <= pk_d;
      pk_e    <= pk_1;
      pk_f    <= pk_e;
      pk_g    <= pk_f;
      dsum_f  <= dterm[0] + dterm[1] + dterm[2];
      dneg_g  <= dsum_f[DW+1];
      dmag_g  <= dsum_f[DW+1] ? DW'(-dsum_f) : dsum_f[DW-1:0];
      dzero_g <= (dsum_f == '0);
    end
  end

  // reciprocal
  logic [P:0]     recip;
  logic [RSW-1:0] rs_out;
  logic           v_r;
  pipe_ctl_t      ctl_g;

  assign ctl_g = '{en: en, valid: v_g};

  mi3_recip #(.DW(DW), .P(P), .SW(RSW)) u_recip (
    .clk, .rst, .ctl(ctl_g), .d(dmag_g), .side_in({dneg_g, dzero_g, pk_g}),
    .valid_out(v_r), .q(recip), .side_out(rs_out)
  );

  // scaled adjugate
  logic [PW-1:0] sprod [9];
  logic          esign [9];
  logic          v_p;
  pipe_ctl_t     ctl_r;

  assign ctl_r = '{en: en, valid: v_r};

  for (genvar e = 0; e < 9; e++) begin : g_scale
    if (e == 0) begin : g_first
      mi3_umul #(.AW(AMW), .BW(P+1), .SW(1)) u_mul (
        .clk, .rst, .ctl(ctl_r), .a(rs_out[e*AMW +: AMW]), .b(recip),
        .side_in(rs_out[9*AMW + e]), .valid_out(v_p), .p(sprod[e]),
        .side_out(esign[e])
      );
    end else begin : g_rest
      mi3_umul #(.AW(AMW), .BW(P+1), .SW(1)) u_mul (
        .clk, .rst, .ctl(ctl_r), .a(rs_out[e*AMW +: AMW]), .b(recip),
        .side_in(rs_out[9*AMW + e]), .valid_out(), .p(sprod[e]),
        .side_out(esign[e])
      );
    end
  end

  // stage H: round and shift; then saturate, or give the identity when singular, into the output register
  logic          dneg_1, dzero_1, dneg_p, dzero_p, dzero_h, v_h;
  logic [RW-1:0] rmag [9];
  logic          rneg [9];
  logic [PW:0]   rsum [9];
  logic [W-1:0]  bval [9];
  logic [W-1:0]  b_q  [9];
  logic          sat_next;
  logic          ng, big;
  logic [RW-1:0] lim;

  always_comb begin
    for (int e = 0; e < 9; e++) rsum[e] = (PW+1)'(sprod[e]) + HALF;
  end

  always_comb begin
    sat_next = 1'b0;
    ng       = 1'b0;
    big      = 1'b0;
    lim      = '0;
    for (int e = 0; e < 9; e++) begin
      if (dzero_h) begin
        bval[e] = (e % 4 == 0) ? ONE_V : '0;
      end else begin
        ng       = rneg[e] && (rmag[e] != '0);
        lim      = ng ? LIM_N : LIM_P;
        big      = rmag[e] > lim;
        bval[e]  = big ? (ng ? W'(-lim[W-1:0]) : lim[W-1:0])
                       : (ng ? W'(-rmag[e][W-1:0]) : rmag[e][W-1:0]);
        sat_next = sat_next | big;
      end
    end
    if (dzero_h) sat_next = ONE_SAT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg_1  <= rs_out[RSW-1];
      dzero_1 <= rs_out[RSW-2];
      dneg_p  <= dneg_1;
      dzero_p <= dzero_1;
      dzero_h <= dzero_p;
      for (int e = 0; e < 9; e++) begin
        rmag[e] <= rsum[e][PW:OS];
        rneg[e] <= esign[e] ^ dneg_p;
      end
      for (int e = 0; e < 9; e++) b_q[e] <= bval[e];
      singular  <= dzero_h;
      saturated <= sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      v_f       <= 1'b0;
      v_g       <= 1'b0;
      v_h       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a       <= in_valid;
      v_c       <= v_b;
      v_d       <= v_c;
      v_f       <= v_e;
      v_g       <= v_f;
      v_h       <= v_p;
      out_valid <= v_h;
    end
  end

  assign b00 = b_q[0];
  assign b01 = b_q[1];
  assign b02 = b_q[2];
  assign b10 = b_q[3];
  assign b11 = b_q[4];
  assign b12 = b_q[5];
  assign b20 = b_q[6];
  assign b21 = b_q[7];
  assign b22 = b_q[8];

endmodule

// File: dv/matrix_inverse_3x3_core_tb.sv
// Self-checking bench for matrix_inverse_3x3_core: Q16.16 inverses against a wide predictor.
// Needs mi3_pkg, mi3_umul, mi3_recip, core; directed corners, then random matrices with random stalls.
`timescale 1ns / 1ps

module matrix_inverse_3x3_core_tb;

  localparam int W = 32;
  localparam int F = 16;
  localparam int RSH = 2 * W + 2 * F + 4;
  localparam int OSH = RSH - 2 * F;
  localparam int LATENCY = 2 * W + 2 * F + 18;
  localparam int N_RANDOM = 1730;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [W-1:0] ONE = 32'h0001_0000;
  localparam logic [W-1:0] MAXP = 32'h7fff_ffff;
  localparam logic [W-1:0] MAXN = 32'h8000_0000;

  typedef struct {
    logic [8:0][W-1:0] a;
  } matrix_t;

  typedef struct {
    logic [8:0][W-1:0] b;
    logic              singular;
    logic              saturated;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0;
  logic signed [W-1:0] a12 = '0, a20 = '0, a21 = '0, a22 = '0;
  logic signed [W-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic singular, saturated;

  matrix_t  pending_mats[$];
  inverse_t expected_invs[$];
  int       n_total = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_errors = 0;
  int       n_singular = 0;
  int       n_sat = 0;
  int       cycle = 0;
  logic     stim_done = 1'b0;

  matrix_inverse_3x3_core #(.ELEM_WIDTH(W), .FRAC_BITS(F)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .a00(a00), .a01(a01), .a02(a02), .a10(a10), .a11(a11), .a12(a12),
    .a20(a20), .a21(a21), .a22(a22),
    .out_valid(out_valid), .out_ready(out_ready),
    .b00(b00), .b01(b01), .b02(b02), .b10(b10), .b11(b11), .b12(b12),
    .b20(b20), .b21(b21), .b22(b22),
    .singular(singular), .saturated(saturated)
  );

  always #5 clk = ~clk;

  function automatic inverse_t invert(matrix_t m);
    logic signed [255:0] x[9];
    logic signed [255:0] adj[9];
    logic signed [255:0] det;
    logic [255:0] dmag, recip, amag, p;
    logic neg;
    inverse_t r;
    for (int i = 0; i < 9; i++) x[i] = {{(256-W){m.a[i][W-1]}}, m.a[i]};
    adj[0] = x[4] * x[8] - x[7] * x[5];
    adj[1] = x[2] * x[7] - x[1] * x[8];
    adj[2] = x[1] * x[5] - x[2] * x[4];
    adj[3] = x[5] * x[6] - x[3] * x[8];
    adj[4] = x[0] * x[8] - x[2] * x[6];
    adj[5] = x[3] * x[2] - x[0] * x[5];
    adj[6] = x[3] * x[7] - x[6] * x[4];
    adj[7] = x[6] * x[1] - x[0] * x[7];
    adj[8] = x[0] * x[4] - x[3] * x[1];
    det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
    r.saturated = 1'b0;
    if (det == 0) begin
      r.singular = 1'b1;
      for (int i = 0; i < 9; i++) r.b[i] = (i / 3 == i % 3) ? ONE : '0;
      return r;
    end
    r.singular = 1'b0;
    dmag = det[255] ? -det : det;
    recip = (256'd1 << RSH) / dmag;
    for (int i = 0; i < 9; i++) begin
      amag = adj[i][255] ? -adj[i] : adj[i];
      p = (amag * recip + (256'd1 << (OSH - 1))) >> OSH;
      neg = (adj[i][255] != det[255]) && (p != 0);
      if (neg && p > 256'h8000_0000) begin
        p = 256'h8000_0000;
        r.saturated = 1'b1;
      end else if (!neg && p > 256'h7fff_ffff) begin
        p = 256'h7fff_ffff;
        r.saturated = 1'b1;
      end
      r.b[i] = neg ? -p[W-1:0] : p[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] rand_elem(int mode);
    logic [W-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $urandom_range(3 * 65536) - 32'd98304;
      2: v = $urandom_range(255) - 32'd128;
      default: begin
        case ($urandom_range(3))
          0: v = MAXP;
          1: v = MAXN;
          2: v = '0;
          default: v = ONE;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_mat(logic [W-1:0] e0, logic [W-1:0] e1, logic [W-1:0] e2,
                         logic [W-1:0] e3, logic [W-1:0] e4, logic [W-1:0] e5,
                         logic [W-1:0] e6, logic [W-1:0] e7, logic [W-1:0] e8);
    matrix_t m;
    m.a = {e8, e7, e6, e5, e4, e3, e2, e1, e0};
    pending_mats.insert(pending_mats.size(), m);
    n_total++;
  endtask

  // driver
  always @(posedge clk) begin
    matrix_t  m;
    inverse_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        m.a = {a22, a21, a20, a12, a11, a10, a02, a01, a00};
        e = invert(m);
        expected_invs.insert(expected_invs.size(), e);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_mats.size() > 0 &&
            ((cycle > 3000 && cycle < 5000) || $urandom_range(99) >= 17)) begin
          m = pending_mats.pop_front();
          {a22, a21, a20, a12, a11, a10, a02, a01, a00} <= m.a;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    inverse_t e;
    logic [8:0][W-1:0] got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {b22, b21, b20, b12, b11, b10, b02, b01, b00};
        if (expected_invs.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected transaction at cycle %0d", cycle);
        end else begin
          e = expected_invs.pop_front();
          n_checked++;
          if (e.singular) n_singular++;
          if (e.saturated) n_sat++;
          if (got !== e.b || singular !== e.singular || saturated !== e.saturated) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch at cycle %0d, result %0d", cycle, n_checked);
              $display("  exp b=%h sing=%b sat=%b", e.b, e.singular, e.saturated);
              $display("  got b=%h sing=%b sat=%b", got, singular, saturated);
            end
          end
        end
      end
      out_ready <= (cycle > 6000 && cycle < 8000) || $urandom_range(99) >= 17;
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d results pending", cycle, expected_invs.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int mode;
    logic [W-1:0] e[9];
    // identity, zero, scaled diagonals, dense MAXP/MAXN and -1 patterns
    add_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
    add_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_mat(32'h2_0000, 0, 0, 0, 32'h4_0000, 0, 0, 0, 32'h8000);
    add_mat(1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_mat(-ONE, 0, 0, 0, 1, 0, 0, 0, -32'sd1);
    add_mat(MAXP, 0, 0, 0, MAXP, 0, 0, 0, MAXP);
    add_mat(MAXN, 0, 0, 0, MAXN, 0, 0, 0, MAXN);
    add_mat(MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN);
    add_mat(MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP);
    add_mat(MAXN, MAXP, 0, MAXP, MAXN, MAXP, 0, MAXP, MAXN);
    add_mat(32'hffff_ffff, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            0, 32'hffff_ffff);
    // rank deficient
    add_mat(ONE, 32'h2_0000, 32'h3_0000, 32'h2_0000, 32'h4_0000, 32'h6_0000, 1, 2, 3);
    add_mat(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
    add_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, 0);
    // permutation and general well-conditioned
    add_mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0);
    add_mat(32'h2_0000, -32'sh1_0000, 0, -32'sh1_0000, 32'h2_0000, -32'sh1_0000, 0,
            -32'sh1_0000, 32'h2_0000);
    add_mat(32'h4000, 32'h1234, 32'h8000, 32'hfff0_0000, 32'h0003_8000, 1, 7, 32'h7fff,
            32'h10_0000);
    add_mat(32'h0000_8000, 0, 0, 0, 32'h0000_8000, 0, 0, 0, 32'h0000_8000);
    add_mat(MAXP, 1, 0, 1, MAXP, 1, 0, 1, MAXP);
    add_mat(1, MAXP, MAXN, 2, 3, 4, MAXN, MAXP, 1);
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(99);
      for (int i = 0; i < 9; i++) begin
        if (mode < 55) e[i] = rand_elem(1);
        else if (mode < 70) e[i] = rand_elem(0);
        else if (mode < 80) e[i] = rand_elem(2);
        else e[i] = rand_elem($urandom_range(3));
      end
      if (mode >= 90) begin
        // dependent row or column gives a zero determinant
        if (mode & 1) for (int c = 0; c < 3; c++) e[6 + c] = e[c];
        else for (int r = 0; r < 3; r++) e[r * 3 + 2] = e[r * 3];
      end
      add_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (n_sent == n_total && expected_invs.size() == 0);
    repeat (LATENCY + 50) @(posedge clk);
    $display("checked %0d inverses of %0d sent matrices, %0d singular, %0d saturated",
             n_checked, n_sent, n_singular, n_sat);
    $display("errors: %0d", n_errors);
    if (n_errors == 0 && expected_invs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
